/* design/rat_pkg.sv */
package rat_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int OUT_WIDTH_DEF   = 40;

  localparam int FRAC       = 30;
  localparam int NORM_WIDTH = 31;
  localparam int ROOT_WIDTH = 32;
  localparam int QUO_WIDTH  = 31;
  localparam int TERM_WIDTH = 31;
  localparam int X2_WIDTH   = 30;
  localparam int SUM_WIDTH  = 34;
  localparam int TAY_STEPS  = 6;

  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_LAST  = 2'd3;

  typedef struct packed {
    logic [63:0]           rem;
    logic [ROOT_WIDTH-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [2:0][63:0]          rem;
    logic [2:0][QUO_WIDTH-1:0] quo;
    logic [ROOT_WIDTH-1:0]     den;
  } div_t;

  typedef struct packed {
    logic [TERM_WIDTH-1:0]       ts;
    logic [TERM_WIDTH-1:0]       tc;
    logic signed [SUM_WIDTH-1:0] sum_s;
    logic signed [SUM_WIDTH-1:0] sum_c;
    logic [X2_WIDTH-1:0]         x2;
  } tay_t;

endpackage

/* design/rat_taylor_cell.sv */
module rat_taylor_cell #(
  parameter int unsigned STEP = 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  rat_pkg::tay_t st_i,
  output rat_pkg::tay_t st_o
);
  import rat_pkg::*;

  localparam int unsigned KS  = (2 * STEP) * (2 * STEP + 1);
  localparam int unsigned KC  = (2 * STEP - 1) * (2 * STEP);
  localparam bit          HAS_SIN = (STEP <= 5);
  localparam bit          NEG     = (STEP % 2 == 1);
  localparam int unsigned SHS = FRAC + $clog2(KS);
  localparam int unsigned SHC = FRAC + $clog2(KC);
  localparam logic [63:0] MS  = ((64'd1 << SHS) + 64'(KS) - 64'd1) / 64'(KS);
  localparam logic [63:0] MC  = ((64'd1 << SHC) + 64'(KC) - 64'd1) / 64'(KC);

  logic [60:0] ps_prod, pc_prod;
  logic [62:0] qs_prod, qc_prod;
  logic [TERM_WIDTH-1:0] qs, qc;
  tay_t mid_d, mid_q, st_d, st_q;

  always_comb begin
    ps_prod = 61'(st_i.ts) * 61'(st_i.x2);
    pc_prod = 61'(st_i.tc) * 61'(st_i.x2);
    mid_d = st_i;
    mid_d.ts = TERM_WIDTH'(ps_prod >> FRAC);
    mid_d.tc = TERM_WIDTH'(pc_prod >> FRAC);
  end

  always_comb begin
    qs_prod = 63'(mid_q.ts) * 63'(MS[31:0]);
    qc_prod = 63'(mid_q.tc) * 63'(MC[31:0]);
    qs = TERM_WIDTH'(qs_prod >> SHS);
    qc = TERM_WIDTH'(qc_prod >> SHC);
    st_d = mid_q;
    st_d.tc = qc;
    if (NEG) begin
      st_d.sum_c = mid_q.sum_c - $signed(SUM_WIDTH'(qc));
    end else begin
      st_d.sum_c = mid_q.sum_c + $signed(SUM_WIDTH'(qc));
    end
    if (HAS_SIN) begin
      st_d.ts = qs;
      if (NEG) begin
        st_d.sum_s = mid_q.sum_s - $signed(SUM_WIDTH'(qs));
      end else begin
        st_d.sum_s = mid_q.sum_s + $signed(SUM_WIDTH'(qs));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= mid_d;
      st_q  <= st_d;
    end
  end

  assign st_o = st_q;

endmodule

/* design/rat_sqrt_cell.sv */
module rat_sqrt_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  rat_pkg::sqrt_t st_i,
  output rat_pkg::sqrt_t st_o
);
  import rat_pkg::*;

  logic [65:0] trial;
  sqrt_t st_d, st_q;

  always_comb begin
    trial = (66'(st_i.root) << (BIT + 1)) + (66'd1 << (2 * BIT));
    st_d = st_i;
    if (66'(st_i.rem) >= trial) begin
      st_d.rem  = st_i.rem - trial[63:0];
      st_d.root = st_i.root | (ROOT_WIDTH'(1) << BIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

endmodule

/* design/rat_div_cell.sv */
module rat_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  rat_pkg::div_t st_i,
  output rat_pkg::div_t st_o
);
  import rat_pkg::*;

  logic [63:0] cmp;
  div_t st_d, st_q;

  always_comb begin
    cmp = 64'(st_i.den) << BIT;
    st_d = st_i;
    for (int l = 0; l < 3; l++) begin
      if (st_i.rem[l] >= cmp) begin
        st_d.rem[l] = st_i.rem[l] - cmp;
        st_d.quo[l] = st_i.quo[l] | (QUO_WIDTH'(1) << BIT);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

endmodule

/* design/axis_rotation_transform.sv */
// An accepted item runs through the pipeline into a row buffer; its rows then follow one per
// cycle while out_ready_i is high, and the next item loads as the last of its four rows is taken.
// Items are taken back to back until an item at the end of the 84-stage pipeline finds the row buffer busy.
// The pipeline is a row of sine/cosine series cells, one square root cell per root bit
// and one divider cell per quotient bit. Reset clears only the valid bits and row counter.
module axis_rotation_transform #(
  parameter int ANGLE_WIDTH = rat_pkg::ANGLE_WIDTH_DEF,
  parameter int OUT_WIDTH   = rat_pkg::OUT_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [rat_pkg::COORD_WIDTH-1:0] a_x_i,
  input  logic signed [rat_pkg::COORD_WIDTH-1:0] a_y_i,
  input  logic signed [rat_pkg::COORD_WIDTH-1:0] a_z_i,
  input  logic signed [rat_pkg::COORD_WIDTH-1:0] b_x_i,
  input  logic signed [rat_pkg::COORD_WIDTH-1:0] b_y_i,
  input  logic signed [rat_pkg::COORD_WIDTH-1:0] b_z_i,
  input  logic        [ANGLE_WIDTH-1:0]          angle_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic        [1:0]                      row_index_o,
  output logic signed [OUT_WIDTH-1:0]            col0_o,
  output logic signed [OUT_WIDTH-1:0]            col1_o,
  output logic signed [OUT_WIDTH-1:0]            col2_o,
  output logic signed [OUT_WIDTH-1:0]            col3_o,
  output logic                                   degenerate_axis_o,
  output logic                                   last_row_o
);
  import rat_pkg::*;

  localparam int POS_W    = $clog2(DIFF_WIDTH);
  localparam int TAY_DONE = 2 * TAY_STEPS;
  localparam int SQ_START = TAY_DONE + 1;
  localparam int SQ_DONE  = SQ_START + ROOT_WIDTH;
  localparam int DIV_DONE = SQ_DONE + QUO_WIDTH;
  localparam int SB_LEN   = DIV_DONE + 2;
  localparam int VLEN     = 2 + SB_LEN + 4;

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  localparam logic signed [65:0] OUT_MAX = (66'sd1 <<< (OUT_WIDTH - 1)) - 66'sd1;
  localparam logic signed [65:0] OUT_MIN = -OUT_MAX - 66'sd1;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
  localparam logic signed [OUT_WIDTH-1:0] ONE_OUT = OUT_WIDTH'(64'sd1048576);

  typedef struct packed {
    logic [2:0][COORD_WIDTH-1:0] a;
    logic [2:0]                  neg;
    logic                        degen;
    logic [1:0]                  quad;
    logic                        swap;
    logic [2:0][NORM_WIDTH-1:0]  nmag;
    logic [63:0]                 n2;
    logic [TERM_WIDTH-1:0]       x;
    logic [X2_WIDTH-1:0]         x2;
    logic [31:0]                 s;
    logic [31:0]                 c;
    logic [2:0][31:0]            u;
  } sb_t;

  function automatic logic signed [OUT_WIDTH-1:0] sat_out(input logic signed [65:0] v);
    logic signed [65:0] r;
    r = v;
    if (v > OUT_MAX) begin
      r = OUT_MAX;
    end else if (v < OUT_MIN) begin
      r = OUT_MIN;
    end
    return OUT_WIDTH'(r);
  endfunction

  function automatic logic signed [31:0] clamp_unit(input logic signed [SUM_WIDTH-1:0] v);
    logic signed [31:0] r;
    r = 32'(v);
    if (v < 0) begin
      r = 32'sd0;
    end else if (v > SUM_WIDTH'(ONE_Q30)) begin
      r = ONE_Q30;
    end
    return r;
  endfunction

  logic en, load, out_fire;
  logic [VLEN-1:0] v_q;

  // Entry stage.
  logic signed [COORD_WIDTH-1:0] a_in [3];
  logic signed [COORD_WIDTH-1:0] b_in [3];
  logic signed [DIFF_WIDTH-1:0]  diff [3];
  logic [31:0] pang;
  logic [29:0] fang;
  logic signed [COORD_WIDTH-1:0] p0_a_q [3];
  logic [DIFF_WIDTH-1:0]         p0_mag_q [3];
  logic [2:0]                    p0_neg_q;
  logic [1:0]                    p0_quad_q;
  logic                          p0_swap_q;
  logic [29:0]                   p0_f_q;

  assign a_in[0] = a_x_i;
  assign a_in[1] = a_y_i;
  assign a_in[2] = a_z_i;
  assign b_in[0] = b_x_i;
  assign b_in[1] = b_y_i;
  assign b_in[2] = b_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = DIFF_WIDTH'(b_in[i]) - DIFF_WIDTH'(a_in[i]);
    end
    pang = 32'(angle_i) << (32 - ANGLE_WIDTH);
    fang = pang[29:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p0_a_q[i]   <= a_in[i];
        p0_neg_q[i] <= diff[i][DIFF_WIDTH-1];
        p0_mag_q[i] <= diff[i][DIFF_WIDTH-1] ? DIFF_WIDTH'(-diff[i]) : DIFF_WIDTH'(diff[i]);
      end
      p0_quad_q <= pang[31:30];
      p0_swap_q <= fang[29];
      p0_f_q    <= fang[29] ? 30'(31'h40000000 - 31'(fang)) : fang;
    end
  end

  // Normalization of the direction and angle scaling.
  logic [DIFF_WIDTH-1:0] mmax;
  logic [POS_W-1:0]      pos;
  logic [63:0]           nm_w [3];
  logic [61:0]           xprod;
  logic signed [COORD_WIDTH-1:0] p1_a_q [3];
  logic [NORM_WIDTH-1:0] p1_nmag_q [3];
  logic [2:0]            p1_neg_q;
  logic [1:0]            p1_quad_q;
  logic                  p1_swap_q;
  logic                  p1_degen_q;
  logic [TERM_WIDTH-1:0] p1_x_q;

  always_comb begin
    mmax = p0_mag_q[0];
    for (int i = 1; i < 3; i++) begin
      if (p0_mag_q[i] > mmax) begin
        mmax = p0_mag_q[i];
      end
    end
    pos = '0;
    for (int b = 0; b < DIFF_WIDTH; b++) begin
      if (mmax[b]) begin
        pos = POS_W'(b);
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (pos > POS_W'(FRAC)) begin
        nm_w[i] = 64'(p0_mag_q[i]) >> (pos - POS_W'(FRAC));
      end else begin
        nm_w[i] = 64'(p0_mag_q[i]) << (POS_W'(FRAC) - pos);
      end
    end
    xprod = 62'(p0_f_q) * 62'(PI_Q30);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_a_q[i]    <= p0_a_q[i];
        p1_nmag_q[i] <= nm_w[i][NORM_WIDTH-1:0];
      end
      p1_neg_q   <= p0_neg_q;
      p1_quad_q  <= p0_quad_q;
      p1_swap_q  <= p0_swap_q;
      p1_degen_q <= (mmax == '0);
      p1_x_q     <= xprod[61:31];
    end
  end

  // Sideband line that runs beside the cell chains.
  sb_t sb_q [SB_LEN];
  sb_t sb0_d;
  sb_t sb_tay_d;
  sb_t sb_div_d;
  logic [61:0] xx;
  logic signed [31:0] s0, c0, sq, cq, s_d, c_d;
  logic [2:0][31:0] u_d;
  logic [QUO_WIDTH-1:0] qcap;

  tay_t  tay_s [TAY_STEPS+1];
  sqrt_t sq_s  [ROOT_WIDTH+1];
  div_t  dv_s  [QUO_WIDTH+1];
  div_t  dv_in;

  always_comb begin
    sb0_d = '0;
    sb0_d.n2 = '0;
    for (int i = 0; i < 3; i++) begin
      sb0_d.a[i]    = p1_a_q[i];
      sb0_d.nmag[i] = p1_nmag_q[i];
      sb0_d.n2      = sb0_d.n2 + 64'(p1_nmag_q[i]) * 64'(p1_nmag_q[i]);
    end
    sb0_d.neg   = p1_neg_q;
    sb0_d.degen = p1_degen_q;
    sb0_d.quad  = p1_quad_q;
    sb0_d.swap  = p1_swap_q;
    sb0_d.x     = p1_x_q;
    xx = 62'(p1_x_q) * 62'(p1_x_q);
    sb0_d.x2 = xx[59:30];
  end

  assign tay_s[0] = '{ts: sb_q[0].x, tc: TERM_WIDTH'(ONE_Q30),
                      sum_s: $signed(SUM_WIDTH'(sb_q[0].x)),
                      sum_c: $signed(SUM_WIDTH'(ONE_Q30)), x2: sb_q[0].x2};

  for (genvar g = 0; g < TAY_STEPS; g++) begin : g_tay
    rat_taylor_cell #(.STEP(g + 1)) u_tay (
      .clk_i (clk_i),
      .en_i  (en),
      .st_i  (tay_s[g]),
      .st_o  (tay_s[g+1])
    );
  end

  always_comb begin
    s0 = clamp_unit(tay_s[TAY_STEPS].sum_s);
    c0 = clamp_unit(tay_s[TAY_STEPS].sum_c);
    sq = sb_q[TAY_DONE].swap ? c0 : s0;
    cq = sb_q[TAY_DONE].swap ? s0 : c0;
    unique case (sb_q[TAY_DONE].quad)
      QUAD_I: begin
        s_d = sq;
        c_d = cq;
      end
      QUAD_II: begin
        s_d = cq;
        c_d = -sq;
      end
      QUAD_III: begin
        s_d = -sq;
        c_d = -cq;
      end
      QUAD_IV: begin
        s_d = -cq;
        c_d = sq;
      end
      default: begin
        s_d = sq;
        c_d = cq;
      end
    endcase
  end

  assign sq_s[0] = '{rem: sb_q[SQ_START].n2, root: '0};

  for (genvar g = 0; g < ROOT_WIDTH; g++) begin : g_sqrt
    rat_sqrt_cell #(.BIT(ROOT_WIDTH - 1 - g)) u_sqrt (
      .clk_i (clk_i),
      .en_i  (en),
      .st_i  (sq_s[g]),
      .st_o  (sq_s[g+1])
    );
  end

  always_comb begin
    dv_in = '0;
    dv_in.den = sq_s[ROOT_WIDTH].root;
    for (int i = 0; i < 3; i++) begin
      dv_in.rem[i] = (64'(sb_q[SQ_DONE].nmag[i]) << FRAC) +
                     64'(sq_s[ROOT_WIDTH].root >> 1);
    end
  end

  assign dv_s[0] = dv_in;

  for (genvar g = 0; g < QUO_WIDTH; g++) begin : g_div
    rat_div_cell #(.BIT(QUO_WIDTH - 1 - g)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .st_i  (dv_s[g]),
      .st_o  (dv_s[g+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qcap = dv_s[QUO_WIDTH].quo[i];
      if (qcap > QUO_WIDTH'(ONE_Q30)) begin
        qcap = QUO_WIDTH'(ONE_Q30);
      end
      if (sb_q[DIV_DONE].degen) begin
        u_d[i] = (i == 0) ? ONE_Q30 : 32'sd0;
      end else if (sb_q[DIV_DONE].neg[i]) begin
        u_d[i] = -32'(qcap);
      end else begin
        u_d[i] = 32'(qcap);
      end
    end
  end

  always_comb begin
    sb_tay_d   = sb_q[TAY_DONE];
    sb_tay_d.s = s_d;
    sb_tay_d.c = c_d;
    sb_div_d   = sb_q[DIV_DONE];
    sb_div_d.u = u_d;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= sb0_d;
      for (int k = 1; k < SB_LEN; k++) begin
        if (k == TAY_DONE + 1) begin
          sb_q[k] <= sb_tay_d;
        end else if (k == DIV_DONE + 1) begin
          sb_q[k] <= sb_div_d;
        end else begin
          sb_q[k] <= sb_q[k-1];
        end
      end
    end
  end

  // Matrix stages.
  logic signed [63:0] uu_p [3][3];
  logic signed [63:0] su_p [3];
  logic signed [65:0] r0_p [3][3];
  logic signed [34:0] acc  [3][3];
  logic signed [31:0] m1_uu_q [3][3];
  logic signed [31:0] m1_su_q [3];
  logic signed [32:0] m1_omc_q;
  logic signed [31:0] m1_c_q;
  logic signed [COORD_WIDTH-1:0] m1_a_q [3];
  logic               m1_degen_q;
  logic signed [33:0] m2_r0_q [3][3];
  logic signed [31:0] m2_su_q [3];
  logic signed [31:0] m2_c_q;
  logic signed [COORD_WIDTH-1:0] m2_a_q [3];
  logic               m2_degen_q;
  logic signed [31:0] m3_r_q [3][3];
  logic signed [COORD_WIDTH-1:0] m3_a_q [3];
  logic               m3_degen_q;
  logic signed [63:0] t1_p_q [3][3];
  logic signed [31:0] t1_r_q [3][3];
  logic signed [COORD_WIDTH-1:0] t1_a_q [3];
  logic               t1_degen_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      su_p[i] = $signed(sb_q[SB_LEN-1].s) * $signed(sb_q[SB_LEN-1].u[i]);
      for (int j = 0; j < 3; j++) begin
        uu_p[i][j] = $signed(sb_q[SB_LEN-1].u[i]) * $signed(sb_q[SB_LEN-1].u[j]);
        r0_p[i][j] = m1_omc_q * m1_uu_q[i][j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc[i][j] = 35'(m2_r0_q[i][j]) + ((i == j) ? 35'(m2_c_q) : 35'sd0);
      end
    end
    acc[0][1] = acc[0][1] + 35'(m2_su_q[2]);
    acc[0][2] = acc[0][2] - 35'(m2_su_q[1]);
    acc[1][0] = acc[1][0] - 35'(m2_su_q[2]);
    acc[1][2] = acc[1][2] + 35'(m2_su_q[0]);
    acc[2][0] = acc[2][0] + 35'(m2_su_q[1]);
    acc[2][1] = acc[2][1] - 35'(m2_su_q[0]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1_su_q[i] <= 32'((su_p[i] + 64'sd536870912) >>> FRAC);
        m1_a_q[i]  <= $signed(sb_q[SB_LEN-1].a[i]);
        m2_su_q[i] <= m1_su_q[i];
        m2_a_q[i]  <= m1_a_q[i];
        m3_a_q[i]  <= m2_a_q[i];
        t1_a_q[i]  <= m3_a_q[i];
        for (int j = 0; j < 3; j++) begin
          m1_uu_q[i][j] <= 32'((uu_p[i][j] + 64'sd536870912) >>> FRAC);
          m2_r0_q[i][j] <= 34'((r0_p[i][j] + 66'sd536870912) >>> FRAC);
          if (acc[i][j] > 35'(ONE_Q30)) begin
            m3_r_q[i][j] <= ONE_Q30;
          end else if (acc[i][j] < -35'(ONE_Q30)) begin
            m3_r_q[i][j] <= -ONE_Q30;
          end else begin
            m3_r_q[i][j] <= 32'(acc[i][j]);
          end
          t1_p_q[i][j] <= m3_r_q[i][j] * m3_a_q[j];
          t1_r_q[i][j] <= m3_r_q[i][j];
        end
      end
      m1_omc_q   <= 33'(ONE_Q30) - 33'($signed(sb_q[SB_LEN-1].c));
      m1_c_q     <= $signed(sb_q[SB_LEN-1].c);
      m1_degen_q <= sb_q[SB_LEN-1].degen;
      m2_c_q     <= m1_c_q;
      m2_degen_q <= m1_degen_q;
      m3_degen_q <= m2_degen_q;
      t1_degen_q <= m3_degen_q;
    end
  end

  // Translation and the row buffer.
  logic signed [65:0] tsum [3];
  logic signed [65:0] tdiff [3];
  logic signed [OUT_WIDTH-1:0] col_d [3][4];
  logic signed [OUT_WIDTH-1:0] buf_col_q [3][4];
  logic                        buf_degen_q;
  logic                        buf_valid_q;
  logic [1:0]                  row_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tsum[i] = 66'(t1_p_q[i][0]) + 66'(t1_p_q[i][1]) + 66'(t1_p_q[i][2]) +
                66'sd536870912;
      tdiff[i] = 66'(t1_a_q[i]) - (tsum[i] >>> FRAC);
      for (int j = 0; j < 3; j++) begin
        col_d[i][j] = sat_out((66'(t1_r_q[i][j]) + 66'sd512) >>> 10);
      end
      col_d[i][3] = sat_out(tdiff[i]);
    end
  end

  assign out_fire = buf_valid_q && out_ready_i;
  assign load     = v_q[VLEN-1] && (!buf_valid_q || (out_ready_i && row_q == ROW_LAST));
  assign en       = !v_q[VLEN-1] || load;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      buf_valid_q <= 1'b0;
      row_q       <= ROW_FIRST;
    end else begin
      if (en) begin
        v_q <= {v_q[VLEN-2:0], in_valid_i};
      end
      if (out_fire) begin
        row_q <= row_q + 2'd1;
      end
      if (load) begin
        buf_valid_q <= 1'b1;
      end else if (out_fire && row_q == ROW_LAST) begin
        buf_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_col_q   <= col_d;
      buf_degen_q <= t1_degen_q;
    end
  end

  always_comb begin
    if (row_q == ROW_LAST) begin
      col0_o = '0;
      col1_o = '0;
      col2_o = '0;
      col3_o = ONE_OUT;
    end else begin
      col0_o = buf_col_q[row_q][0];
      col1_o = buf_col_q[row_q][1];
      col2_o = buf_col_q[row_q][2];
      col3_o = buf_col_q[row_q][3];
    end
  end

  assign out_valid_o       = buf_valid_q;
  assign row_index_o       = row_q;
  assign degenerate_axis_o = buf_degen_q;
  assign last_row_o        = (row_q == ROW_LAST);

`ifndef ASSERT_OFF
  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_row_o |=>
      out_valid_o && row_index_o == $past(row_index_o) + 2'd1)
    else $error("Rows of one item are not delivered in sequence.");

  a_degen_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_row_o |=>
      degenerate_axis_o == $past(degenerate_axis_o))
    else $error("Degenerate flag changed within one item.");

  a_degen_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_axis_o && row_index_o == ROW_FIRST |->
      col0_o == ONE_OUT && col1_o == '0 && col2_o == '0)
    else $error("Degenerate axis did not give a rotation about x.");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v_q[VLEN-1] && buf_valid_q)
    else $error("Input stalled without a full pipeline end.");
`endif

endmodule
